@@ hw/rtl/cmyg_pkg.sv @@
// Shared types, constants and slot tables for the CMYG mosaic to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package cmyg_pkg;

    localparam int DATA_W        = 16;
    localparam int POS_W         = 3;
    localparam int IMG_W_W       = 11;
    localparam int ROW_W         = 16;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int SUM3_W        = DATA_W + 2;
    localparam int RECIP_SHIFT   = 19;

    localparam logic [POS_W-1:0]   POS_RST   = 3'd5;
    localparam logic [IMG_W_W-1:0] WIDTH_RST = 11'd1024;

    // Register select is address bit 2 (registers sit on 32-bit words).
    localparam logic REG_MOSAIC_POS = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;

    // ceil(2^19 / 3); exact floor division by three for sums below 2^19.
    localparam logic [SUM3_W-1:0] RECIP3 = 18'd174763;

    typedef logic [DATA_W-1:0] t_px;

    typedef enum logic [1:0] {
        SLOT_CUR   = 2'd0,
        SLOT_LEFT  = 2'd1,
        SLOT_ABOVE = 2'd2,
        SLOT_ALEFT = 2'd3
    } t_slot;

    // Window samples, indexed by t_slot.
    typedef t_px [3:0] t_win;

    function automatic t_slot yel_slot(input logic [2:0] phase);
        t_slot s;
        case (phase)
            3'd0, 3'd4: s = SLOT_LEFT;
            3'd1, 3'd5: s = SLOT_CUR;
            3'd2, 3'd6: s = SLOT_ALEFT;
            default:    s = SLOT_ABOVE;
        endcase
        return s;
    endfunction

    function automatic t_slot cya_slot(input logic [2:0] phase);
        t_slot s;
        case (phase)
            3'd0, 3'd4: s = SLOT_CUR;
            3'd1, 3'd5: s = SLOT_LEFT;
            3'd2, 3'd6: s = SLOT_ABOVE;
            default:    s = SLOT_ALEFT;
        endcase
        return s;
    endfunction

    function automatic t_slot mag_slot(input logic [2:0] phase);
        t_slot s;
        case (phase)
            3'd0:    s = SLOT_ABOVE;
            3'd1:    s = SLOT_ALEFT;
            3'd2:    s = SLOT_LEFT;
            3'd3:    s = SLOT_CUR;
            3'd4:    s = SLOT_ALEFT;
            3'd5:    s = SLOT_ABOVE;
            3'd6:    s = SLOT_CUR;
            default: s = SLOT_LEFT;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cmyg_if.sv @@
// Stream interfaces for mosaic pixel items and RGB result items.
`timescale 1ns / 1ps
`default_nettype none

interface cmyg_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface cmyg_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] luminance;

    modport source (output valid, output red, output green, output blue,
                    output luminance, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input luminance, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cmyg_cfg.sv @@
// APB register file holding the mosaic position and image width.
`timescale 1ns / 1ps
`default_nettype none

module cmyg_cfg
    import cmyg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    output logic      [POS_W-1:0]   o_pos,
    output logic      [IMG_W_W-1:0] o_width
);

    logic [POS_W-1:0]   r_pos;
    logic [IMG_W_W-1:0] r_width;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_RST;
            r_width <= WIDTH_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_MOSAIC_POS) begin
                r_pos <= pwdata[POS_W-1:0];
            end else begin
                r_width <= pwdata[IMG_W_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_MOSAIC_POS) begin
            prdata = APB_DW'(r_pos);
        end else begin
            prdata = APB_DW'(r_width);
        end
    end

    assign o_pos   = r_pos;
    assign o_width = r_width;

endmodule

`default_nettype wire

@@ hw/rtl/cmyg_line_mem.sv @@
// Single-port line buffer, read-before-write, registered read.
`timescale 1ns / 1ps
`default_nettype none

module cmyg_line_mem
    import cmyg_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_px           i_wdata,
    output t_px                o_rdata
);

    t_px mem [DEPTH];
    t_px r_rdata;

    // The old entry is returned while the new sample replaces it.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdata <= '0;
        end else if (i_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/cmyg_color.sv @@
// Color stages: slot selection and pair sums, then luminance and output register.
`timescale 1ns / 1ps
`default_nettype none

module cmyg_color
    import cmyg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [2:0] i_phase,
    input  wire t_win       i_win,
    output logic            o_adv,
    cmyg_rgb_if.source      o_rgb
);

    logic              r_v2;
    t_px               r_red2;
    t_px               r_grn2;
    t_px               r_blu2;
    logic [SUM3_W-1:0] r_sum2;

    logic              r_v3;
    t_px               r_red3;
    t_px               r_grn3;
    t_px               r_blu3;
    t_px               r_lum3;

    logic [DATA_W:0]       w_my;
    logic [DATA_W:0]       w_cy;
    logic [DATA_W:0]       w_mc;
    logic [SUM3_W-1:0]     w_sum;
    logic [2*SUM3_W-1:0]   w_prod;
    t_px                   w_y;
    t_px                   w_c;
    t_px                   w_m;

    // The whole pipe moves together whenever the output slot is free or drains.
    assign o_adv = !r_v3 || o_rgb.ready;

    always_comb begin
        w_y   = i_win[yel_slot(i_phase)];
        w_c   = i_win[cya_slot(i_phase)];
        w_m   = i_win[mag_slot(i_phase)];
        w_my  = {1'b0, w_m} + {1'b0, w_y};
        w_cy  = {1'b0, w_c} + {1'b0, w_y};
        w_mc  = {1'b0, w_m} + {1'b0, w_c};
        w_sum = SUM3_W'(w_mc) + SUM3_W'(w_y);
    end

    assign w_prod = r_sum2 * RECIP3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (o_adv) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_red2 <= w_my[DATA_W:1];
            r_grn2 <= w_cy[DATA_W:1];
            r_blu2 <= w_mc[DATA_W:1];
            r_sum2 <= w_sum;
            r_red3 <= r_red2;
            r_grn3 <= r_grn2;
            r_blu3 <= r_blu2;
            r_lum3 <= w_prod[RECIP_SHIFT +: DATA_W];
        end
    end

    assign o_rgb.valid     = r_v3;
    assign o_rgb.red       = r_red3;
    assign o_rgb.green     = r_grn3;
    assign o_rgb.blue      = r_blu3;
    assign o_rgb.luminance = r_lum3;

endmodule

`default_nettype wire

@@ hw/rtl/cmyg_mosaic_to_rgb.sv @@
// Top level: CMYG 2x2 mosaic to RGB and luminance converter.
// A result item passes the window, pair-sum and output registers before it is offered.
// Throughput: one pixel item per cycle, set by the single-port line buffer,
// which reads the sample above and writes the current one in the same cycle.
// A result item held by the sink stalls the whole pipe and the pixel side with it.
// Reset clears counters, window samples and valid bits; the line buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module cmyg_mosaic_to_rgb
    import cmyg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cmyg_pix_if.sink               i_pix,
    cmyg_rgb_if.source             o_rgb,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // Column counter indexes the line buffer; the width compare also has to hold
    // the configured width and the buffer depth itself.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;

    logic [POS_W-1:0]   w_pos;
    logic [IMG_W_W-1:0] w_width;
    logic               w_adv;
    logic               w_acc;

    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CW-1:0]      w_col;
    logic [ROW_W-1:0]   w_row;
    logic [EW-1:0]      w_wext;
    logic [EW-1:0]      w_eff;
    logic               w_last;
    logic               w_emit;
    logic [2:0]         w_phase;

    // Stage one: the accepted sample, its left neighbor and the above-left sample.
    // The above sample is the line buffer's registered read data.
    logic               r_v1;
    logic [2:0]         r_phase1;
    t_px                r_cur;
    t_px                r_left;
    t_px                r_aleft;
    t_px                w_above;
    t_win               w_win;

    cmyg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_pos   (w_pos),
        .o_width (w_width)
    );

    assign i_pix.ready = w_adv;
    assign w_acc       = i_pix.valid && w_adv;

    // A frame start restarts the raster at this very pixel.
    always_comb begin
        w_col  = i_pix.frame_start ? '0 : r_col;
        w_row  = i_pix.frame_start ? '0 : r_row;
        w_wext = EW'(w_width);
        if (w_wext < EW'(2)) begin
            w_eff = EW'(2);
        end else if (w_wext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_wext;
        end
        // Also ends the row early when the width shrank below the current column.
        w_last  = (EW'(w_col) + EW'(1)) >= w_eff;
        w_emit  = (w_row != '0) && (w_col != '0);
        w_phase = {w_pos[2:1] + w_row[1:0], w_pos[0] ^ w_col[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (w_acc) begin
                if (w_last) begin
                    r_col <= '0;
                    r_row <= w_row + ROW_W'(1);
                end else begin
                    r_col <= w_col + CW'(1);
                    r_row <= w_row;
                end
            end
            if (w_adv) begin
                r_v1 <= w_acc && w_emit;
            end
        end
    end

    // Window history moves only with accepted items, so bubbles leave it intact.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_left  <= '0;
            r_aleft <= '0;
        end else if (w_acc) begin
            r_cur   <= i_pix.pixel;
            r_left  <= r_cur;
            r_aleft <= w_above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_phase1 <= w_phase;
        end
    end

    cmyg_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_acc),
        .i_addr  (w_col),
        .i_wdata (i_pix.pixel),
        .o_rdata (w_above)
    );

    always_comb begin
        w_win             = '0;
        w_win[SLOT_CUR]   = r_cur;
        w_win[SLOT_LEFT]  = r_left;
        w_win[SLOT_ABOVE] = w_above;
        w_win[SLOT_ALEFT] = r_aleft;
    end

    cmyg_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_phase (r_phase1),
        .i_win   (w_win),
        .o_adv   (w_adv),
        .o_rgb   (o_rgb)
    );

endmodule

`default_nettype wire

@@ hw/rtl/cmyg_checker.sv @@
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cmyg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_red,
    input wire logic [15:0] i_green,
    input wire logic [15:0] i_blue,
    input wire logic [15:0] i_lum
);

    // A result held back by the sink stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red) && $stable(i_green)
        && $stable(i_blue) && $stable(i_lum))
        else $error("result item changed while stalled");

    // A result held back by the sink stops the pixel side in the same cycle.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("pixel item taken while a result item is stalled");

    // The luminance lies between the smallest and largest color channel.
    a_lum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_lum <= i_red || i_lum <= i_green || i_lum <= i_blue)
        && (i_lum >= i_red || i_lum >= i_green || i_lum >= i_blue))
        else $error("luminance outside the color channel range");

    // Nothing is offered in the cycle right after reset.
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result item offered right after reset");

endmodule

bind cmyg_mosaic_to_rgb cmyg_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_lum       (o_rgb.luminance)
);

`default_nettype wire

@@ tb/cmyg_mosaic_to_rgb_chk.sv @@
// Checker that predicts and compares the RGB items of the CMYG mosaic converter.
`timescale 1ns / 1ps

module cmyg_mosaic_to_rgb_chk
    import cmyg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmyg_pix_if               i_pix,
    cmyg_rgb_if               i_rgb,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_errors,
    output int                o_rgb_due
);

    typedef struct packed {
        t_px red;
        t_px green;
        t_px blue;
        t_px luminance;
    } t_rgb;

    t_rgb             rgb_due_q [$];
    t_px              above_row [MAX_WIDTH];
    t_px              left_px;
    t_px              above_left_px;
    int unsigned      col_idx;
    logic [ROW_W-1:0] row_idx;
    logic [POS_W-1:0] mosaic_pos;
    logic [IMG_W_W-1:0] img_width;
    int               err_cnt = 0;
    int               rgb_seen = 0;

    task automatic log_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Advances the window by one mosaic sample and, off the first row and column, queues its RGB item.
    task automatic demosaic_step(input t_px px, input logic frame_start);
        t_win             win;
        logic [2:0]       phase;
        logic [SUM3_W-1:0] yel;
        logic [SUM3_W-1:0] cya;
        logic [SUM3_W-1:0] mag;
        int unsigned      eff_w;
        t_rgb             rgb;
        if (frame_start) begin
            col_idx = 0;
            row_idx = '0;
        end
        win[SLOT_CUR]   = px;
        win[SLOT_LEFT]  = left_px;
        win[SLOT_ABOVE] = above_row[col_idx];
        win[SLOT_ALEFT] = above_left_px;
        if (row_idx != 0 && col_idx != 0) begin
            phase = {2'(mosaic_pos[2:1] + row_idx[1:0]), mosaic_pos[0] ^ col_idx[0]};
            // Cyan follows the low phase bits, yellow is its horizontal neighbor and
            // magenta sits on the other row, flipped by the column and row parities.
            cya = SUM3_W'(win[phase[1:0]]);
            yel = SUM3_W'(win[{phase[1], ~phase[0]}]);
            mag = SUM3_W'(win[{~phase[1], ^phase}]);
            rgb.red       = t_px'((mag + yel) >> 1);
            rgb.green     = t_px'((cya + yel) >> 1);
            rgb.blue      = t_px'((mag + cya) >> 1);
            rgb.luminance = t_px'((mag + cya + yel) / 3);
            rgb_due_q.push_back(rgb);
        end
        above_left_px = win[SLOT_ABOVE];
        left_px = px;
        above_row[col_idx] = px;
        eff_w = (img_width < 2) ? 2 : (img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
        if (col_idx + 1 >= eff_w) begin
            col_idx = 0;
            row_idx = row_idx + 1'b1;
        end else begin
            col_idx = col_idx + 1;
        end
    endtask

    task automatic check_rgb();
        t_rgb got;
        t_rgb want;
        got.red       = i_rgb.red;
        got.green     = i_rgb.green;
        got.blue      = i_rgb.blue;
        got.luminance = i_rgb.luminance;
        if (rgb_due_q.size() == 0) begin
            log_mismatch($sformatf("item %0d not expected: r %0d g %0d b %0d l %0d",
                rgb_seen, got.red, got.green, got.blue, got.luminance));
        end else begin
            want = rgb_due_q.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.luminance !== want.luminance) begin
                log_mismatch($sformatf(
                    "item %0d: expected r %0d g %0d b %0d l %0d, got r %0d g %0d b %0d l %0d",
                    rgb_seen, want.red, want.green, want.blue, want.luminance,
                    got.red, got.green, got.blue, got.luminance));
            end
        end
        rgb_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb_due_q.delete();
            left_px       = '0;
            above_left_px = '0;
            col_idx       = 0;
            row_idx       = '0;
            mosaic_pos    = POS_RST;
            img_width     = WIDTH_RST;
        end else begin
            if (i_rgb.valid && i_rgb.ready) begin
                check_rgb();
            end
            if (i_pix.valid && i_pix.ready) begin
                demosaic_step(i_pix.pixel, i_pix.frame_start);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_MOSAIC_POS) begin
                    mosaic_pos = i_pwdata[POS_W-1:0];
                end else begin
                    img_width = i_pwdata[IMG_W_W-1:0];
                end
            end
        end
        o_errors  <= err_cnt;
        o_rgb_due <= rgb_due_q.size();
    end

endmodule

@@ tb/cmyg_mosaic_to_rgb_tb.sv @@
// Testbench top: stimulus, flow control and verdict for the CMYG mosaic converter.
`timescale 1ns / 1ps

module cmyg_mosaic_to_rgb_tb;
    import cmyg_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;

    // Registers sit on 32-bit words; the package names the select bit.
    localparam logic [APB_AW-1:0] ADDR_MOSAIC_POS  = {REG_MOSAIC_POS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_IMAGE_WIDTH = {REG_IMAGE_WIDTH, 2'b00};

    // Settle time lets the pipeline run empty before the registers change, since
    // pixels that yield no result item leave nothing to wait for.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;

    // Directed frame at width 4. Two saturated rows give all-ones results, the
    // dark row mixes full and empty samples, and the last rows carry single-bit
    // and near-extreme values. Rows 1 to 4 walk the row phase through all four
    // values while the columns alternate, so every mosaic phase is met.
    localparam t_px DIRECTED_PX [0:19] = '{
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF,
        16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cmyg_pix_if pix_if ();
    cmyg_rgb_if rgb_if ();

    int err_cnt;
    int rgb_due;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The generator follows the row and column of the stream so that it never
    // lets a row above the first read a line store entry that was never
    // written, which would happen after the width grows in the middle of a frame.
    bit               line_seen [MAX_W];
    int unsigned      gen_col = 0;
    logic [ROW_W-1:0] gen_row = '0;
    int unsigned      gen_width = MAX_W;

    always #5 i_clk = ~i_clk;

    cmyg_mosaic_to_rgb #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_rgb   (rgb_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cmyg_mosaic_to_rgb_chk #(
        .MAX_WIDTH(MAX_W)
    ) u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if),
        .i_rgb     (rgb_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (err_cnt),
        .o_rgb_due (rgb_due)
    );

    // The result side stalls at random with the rate of the current idling mode.
    always @(posedge i_clk) begin
        rgb_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Mode 0: the pixel side idles a quarter of the time and the result side
    // almost half. Mode 1 swaps the two. Mode 2 runs both sides flat out.
    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 25;
                recv_idle_pct = 46;
            end
            1: begin
                send_idle_pct = 46;
                recv_idle_pct = 25;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // One APB write: setup phase, access phase, then an idle phase so that
    // back-to-back writes never lower and raise psel in the same step.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes both registers and mirrors the clamped width for the generator.
    task automatic configure(input int pos, input int width);
        write_reg(ADDR_MOSAIC_POS, APB_DW'(pos));
        write_reg(ADDR_IMAGE_WIDTH, APB_DW'(width));
        gen_width = (width < 2) ? 2 : (width > MAX_W) ? MAX_W : width;
    endtask

    // Presents one pixel item and returns at the edge where it is accepted.
    // A frame start is forced when the pixel would otherwise read a line store
    // entry that no earlier row has filled.
    task automatic send_pixel(input t_px px, input logic want_start);
        logic frame_start;
        frame_start = want_start;
        if (!frame_start && gen_row != 0 && !line_seen[gen_col]) begin
            frame_start = 1'b1;
        end
        if (frame_start) begin
            gen_col = 0;
            gen_row = '0;
        end
        line_seen[gen_col] = 1'b1;
        if (gen_col + 1 >= gen_width) begin
            gen_col = 0;
            gen_row = gen_row + 1'b1;
        end else begin
            gen_col = gen_col + 1;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= px;
        pix_if.frame_start <= frame_start;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // A run of random pixels. Most samples are uniform over 16 bits; one in
    // four is pinned to all zeros or all ones. With noise enabled, a stray
    // frame start breaks a row now and then.
    task automatic send_pixels(input int count, input logic new_frame, input logic noisy);
        t_px  px;
        logic frame_start;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(7))
                0:       px = '0;
                1:       px = '1;
                default: px = t_px'($urandom);
            endcase
            frame_start = (k == 0) ? new_frame : (noisy && $urandom_range(63) == 0);
            send_pixel(px, frame_start);
        end
    endtask

    // Stops the pixel side and waits until every predicted RGB item has been
    // taken, then lets the pipeline run empty before anything changes.
    task automatic settle();
        int waited;
        pix_if.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (rgb_due != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int width;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel       = '0;
        pix_if.frame_start = 1'b0;
        rgb_if.ready       = 1'b0;
        set_idling(0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frame: saturated and empty windows and every mosaic phase.
        configure(0, 4);
        for (int k = 0; k < 20; k++) begin
            send_pixel(DIRECTED_PX[k], k == 0);
        end

        // Width shrink in the middle of a row: the stream stops at column 8 of
        // a 16-wide row, and the narrower width then makes the next pixel close it.
        settle();
        configure(3, 16);
        send_pixels(40, 1'b1, 1'b0);
        settle();
        configure(3, 4);
        send_pixels(30, 1'b0, 1'b0);

        // Random phases under each idling mode. The first phase of a mode uses a
        // width at or below the lower clamp. The third phase of the first mode
        // sets 2047, which clamps to the full buffer width, and runs one full row
        // and a bit of the next; the rest use small random widths. The mosaic
        // position steps through all eight values.
        for (int mode = 0; mode < 3; mode++) begin
            set_idling(mode);
            for (int ph = 0; ph < 5; ph++) begin
                settle();
                if (ph == 0) begin
                    width = (mode == 0) ? 1 : (mode == 1) ? 0 : 2;
                end else if (ph == 2 && mode == 0) begin
                    width = 2047;
                end else begin
                    width = $urandom_range(2, 12);
                end
                configure((mode * 5 + ph) % 8, width);
                if (width > MAX_W) begin
                    send_pixels(MAX_W + $urandom_range(8, 40), 1'b1, 1'b0);
                end else begin
                    send_pixels($urandom_range(20, 45), $urandom_range(1), 1'b1);
                end
            end
        end

        settle();
        if (err_cnt == 0 && rgb_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: the slowest legal run takes well under a fifth of this.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cmyg_pkg.sv
hw/rtl/cmyg_if.sv
hw/rtl/cmyg_cfg.sv
hw/rtl/cmyg_line_mem.sv
hw/rtl/cmyg_color.sv
hw/rtl/cmyg_mosaic_to_rgb.sv
hw/rtl/cmyg_checker.sv
tb/cmyg_mosaic_to_rgb_chk.sv
tb/cmyg_mosaic_to_rgb_tb.sv
